// File: rtl/core/cdo_pkg.sv
// cdo_pkg: shared types, field widths, status and register codes and the
// calendar helper functions of the date offset block.
// No dependencies; every other file of the block refers to it by scoped names.
package cdo_pkg;

    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int OFF_W  = 16;
    localparam int WD_W   = 3;
    localparam int ST_W   = 3;
    localparam int DOY_W  = 9;   // day of year, 0..365
    localparam int R_W    = 17;  // signed day count relative to 1 January
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_DAY   = 3'd1;
    localparam logic [ST_W-1:0] ST_BAD_MONTH = 3'd2;
    localparam logic [ST_W-1:0] ST_BAD_YEAR  = 3'd3;
    localparam logic [ST_W-1:0] ST_SAT       = 3'd4;

    localparam logic REG_YEAR_MIN = 1'b0;
    localparam logic REG_YEAR_MAX = 1'b1;

    localparam logic [YEAR_W-1:0] YEAR_MIN_RST = 14'd1902;
    localparam logic [YEAR_W-1:0] YEAR_MAX_RST = 14'd2037;

    localparam logic [MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_MOD,
        S_CHECK,
        S_JAN1,
        S_YEAR,
        S_MONTH,
        S_WDAY,
        S_FINISH
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV,
        OP_MOD,
        OP_CHECK,
        OP_JAN1,
        OP_DEC,
        OP_INC,
        OP_SAT_LO,
        OP_SAT_HI,
        OP_YEAR_END,
        OP_MSTEP,
        OP_MONTH_END,
        OP_WDAY,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic bad;       // start date failed a check
        logic r_neg;     // day count lies before the current year
        logic r_ge_len;  // day count lies past the current year
        logic at_min;    // current year is the lowest allowed
        logic at_max;    // current year is the highest allowed
        logic m_more;    // day count lies past the current month
    } dp_stat_t;

    function automatic logic [DAY_W-1:0] days_in_month(input logic [MON_W-1:0] m,
                                                        input logic leap);
        logic [DAY_W-1:0] n;
        case (m)
            4'd2:                n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            default:             n = 5'd31;
        endcase
        return n;
    endfunction

    // days from 1 January to the first of month m
    function automatic logic [DOY_W-1:0] cum_days(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DOY_W-1:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        if (leap && (m > MON_FEB))
        begin
            n = n + 9'd1;
        end
        return n;
    endfunction

    function automatic logic [DOY_W-1:0] year_len(input logic leap);
        return leap ? 9'd366 : 9'd365;
    endfunction

    // x mod 7 for x below 512: quotient by reciprocal 293/2048
    function automatic logic [WD_W-1:0] mod7(input logic [8:0] x);
        logic [17:0] p;
        logic [6:0]  q;
        logic [9:0]  t;
        p = 18'(x) * 18'd293;
        q = p[17:11];
        t = 10'(x) - 10'(q) * 10'd7;
        return t[WD_W-1:0];
    endfunction

endpackage

// File: rtl/core/cdo_regs.sv
// cdo_regs: APB-style register file holding the valid year range.
// Depends on cdo_pkg for widths, register indexes and reset values.
module cdo_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cdo_pkg::CFG_AW-1:0]   paddr,
    input  logic [cdo_pkg::CFG_DW-1:0]   pwdata,
    output logic [cdo_pkg::CFG_DW-1:0]   prdata,
    output logic                         pready,
    output logic [cdo_pkg::YEAR_W-1:0]   year_min,
    output logic [cdo_pkg::YEAR_W-1:0]   year_max
);

    logic [cdo_pkg::YEAR_W-1:0] year_min_reg;
    logic [cdo_pkg::YEAR_W-1:0] year_max_reg;
    logic                       wr_en;
    logic                       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_min_reg <= cdo_pkg::YEAR_MIN_RST;
            year_max_reg <= cdo_pkg::YEAR_MAX_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                cdo_pkg::REG_YEAR_MIN: year_min_reg <= pwdata[cdo_pkg::YEAR_W-1:0];
                cdo_pkg::REG_YEAR_MAX: year_max_reg <= pwdata[cdo_pkg::YEAR_W-1:0];
                default:               year_min_reg <= year_min_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            cdo_pkg::REG_YEAR_MIN: prdata = cdo_pkg::CFG_DW'(year_min_reg);
            cdo_pkg::REG_YEAR_MAX: prdata = cdo_pkg::CFG_DW'(year_max_reg);
            default:               prdata = '0;
        endcase
    end

    assign year_min = year_min_reg;
    assign year_max = year_max_reg;

endmodule

// File: rtl/core/cdo_ctrl.sv
// cdo_ctrl: sequencer of the date offset block; issues one datapath command
// per cycle and owns the input ready and the result valid.
// Depends on cdo_pkg for the state, command and status types.
module cdo_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  cdo_pkg::dp_stat_t stat,
    output cdo_pkg::dp_cmd_t  cmd
);

    cdo_pkg::ctrl_state_t state_reg;
    cdo_pkg::ctrl_state_t state_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdo_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = cdo_pkg::OP_NONE;
        in_ready   = 1'b0;

        unique case (state_reg)
            cdo_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = cdo_pkg::OP_LOAD;
                    state_next = cdo_pkg::S_DIV;
                end
            end
            cdo_pkg::S_DIV:
            begin
                cmd.op     = cdo_pkg::OP_DIV;
                state_next = cdo_pkg::S_MOD;
            end
            cdo_pkg::S_MOD:
            begin
                cmd.op     = cdo_pkg::OP_MOD;
                state_next = cdo_pkg::S_CHECK;
            end
            cdo_pkg::S_CHECK:
            begin
                cmd.op     = cdo_pkg::OP_CHECK;
                state_next = stat.bad ? cdo_pkg::S_FINISH : cdo_pkg::S_JAN1;
            end
            cdo_pkg::S_JAN1:
            begin
                cmd.op     = cdo_pkg::OP_JAN1;
                state_next = cdo_pkg::S_YEAR;
            end
            cdo_pkg::S_YEAR:
            begin
                if (stat.r_neg)
                begin
                    cmd.op = stat.at_min ? cdo_pkg::OP_SAT_LO : cdo_pkg::OP_DEC;
                end
                else if (stat.r_ge_len)
                begin
                    cmd.op = stat.at_max ? cdo_pkg::OP_SAT_HI : cdo_pkg::OP_INC;
                end
                else
                begin
                    cmd.op     = cdo_pkg::OP_YEAR_END;
                    state_next = cdo_pkg::S_MONTH;
                end
            end
            cdo_pkg::S_MONTH:
            begin
                if (stat.m_more)
                begin
                    cmd.op = cdo_pkg::OP_MSTEP;
                end
                else
                begin
                    cmd.op     = cdo_pkg::OP_MONTH_END;
                    state_next = cdo_pkg::S_WDAY;
                end
            end
            cdo_pkg::S_WDAY:
            begin
                cmd.op     = cdo_pkg::OP_WDAY;
                state_next = cdo_pkg::S_FINISH;
            end
            cdo_pkg::S_FINISH:
            begin
                // hold the finished item until the output slot frees up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op     = cdo_pkg::OP_OUT;
                    state_next = cdo_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cdo_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.op == cdo_pkg::OP_OUT)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/cdo_dpath.sv
// cdo_dpath: datapath of the date offset block: start date checks, year and
// month walk with leap tracking, weekday unit and the result register.
// Depends on cdo_pkg; driven by cdo_ctrl through dp_cmd_t / dp_stat_t.
module cdo_dpath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cdo_pkg::dp_cmd_t              cmd,
    output cdo_pkg::dp_stat_t             stat,
    input  logic [cdo_pkg::YEAR_W-1:0]    year_min,
    input  logic [cdo_pkg::YEAR_W-1:0]    year_max,
    input  logic [cdo_pkg::DAY_W-1:0]     start_day,
    input  logic [cdo_pkg::MON_W-1:0]     start_month,
    input  logic [cdo_pkg::YEAR_W-1:0]    start_year,
    input  logic signed [cdo_pkg::OFF_W-1:0] day_offset,
    output logic [cdo_pkg::DAY_W-1:0]     result_day,
    output logic [cdo_pkg::MON_W-1:0]     result_month,
    output logic [cdo_pkg::YEAR_W-1:0]    result_year,
    output logic [cdo_pkg::WD_W-1:0]      weekday,
    output logic [cdo_pkg::ST_W-1:0]      status
);

    logic [cdo_pkg::DAY_W-1:0]        day_reg;
    logic [cdo_pkg::MON_W-1:0]        month_reg;
    logic [cdo_pkg::YEAR_W-1:0]       year_reg;
    logic signed [cdo_pkg::OFF_W-1:0] off_reg;
    logic [7:0]                       q100_reg;
    logic [6:0]                       r100_reg;
    logic [8:0]                       r400_reg;
    logic signed [cdo_pkg::R_W-1:0]   r_reg;
    logic [8:0]                       sum_reg;
    logic [cdo_pkg::WD_W-1:0]         wd_reg;
    logic [cdo_pkg::ST_W-1:0]         status_reg;

    logic [cdo_pkg::DAY_W-1:0]        res_day_reg;
    logic [cdo_pkg::MON_W-1:0]        res_month_reg;
    logic [cdo_pkg::YEAR_W-1:0]       res_year_reg;
    logic [cdo_pkg::WD_W-1:0]         res_wd_reg;
    logic [cdo_pkg::ST_W-1:0]         res_status_reg;

    logic [26:0]                      q_prod;
    logic                             leap_cur;
    logic                             leap_prev;
    logic [6:0]                       r100_prev;
    logic [8:0]                       r400_prev;
    logic [6:0]                       r100_succ;
    logic [8:0]                       r400_succ;
    logic [1:0]                       y_lo_prev;
    logic [cdo_pkg::DOY_W-1:0]        len_cur;
    logic [cdo_pkg::DOY_W-1:0]        len_prev;
    logic [cdo_pkg::DAY_W-1:0]        dim_cur;
    logic [cdo_pkg::ST_W-1:0]         check_code;
    logic [cdo_pkg::DOY_W-1:0]        doy;
    logic signed [cdo_pkg::R_W-1:0]   r_start;
    logic [2:0]                       c100;
    logic [9:0]                       t4;
    logic [9:0]                       x_jan1;
    logic [cdo_pkg::WD_W-1:0]         wd_mod;
    logic [3:0]                       wd_up;
    logic [3:0]                       wd_down;
    logic [1:0]                       step_up;
    logic [1:0]                       step_down;

    assign q_prod = 27'(year_reg) * 27'd5243;

    // leap rule from the year's residues mod 4, 100 and 400
    assign leap_cur  = (year_reg[1:0] == 2'd0) && ((r400_reg == 9'd0) || (r100_reg != 7'd0));
    assign r100_prev = (r100_reg == 7'd0) ? 7'd99 : r100_reg - 7'd1;
    assign r400_prev = (r400_reg == 9'd0) ? 9'd399 : r400_reg - 9'd1;
    assign r100_succ = (r100_reg == 7'd99) ? 7'd0 : r100_reg + 7'd1;
    assign r400_succ = (r400_reg == 9'd399) ? 9'd0 : r400_reg + 9'd1;
    assign y_lo_prev = year_reg[1:0] - 2'd1;
    assign leap_prev = (y_lo_prev == 2'd0) && ((r400_prev == 9'd0) || (r100_prev != 7'd0));

    assign len_cur  = cdo_pkg::year_len(leap_cur);
    assign len_prev = cdo_pkg::year_len(leap_prev);
    assign dim_cur  = cdo_pkg::days_in_month(month_reg, leap_cur);

    always_comb
    begin
        if ((year_reg < year_min) || (year_reg > year_max))
        begin
            check_code = cdo_pkg::ST_BAD_YEAR;
        end
        else if ((month_reg < cdo_pkg::MON_JAN) || (month_reg > cdo_pkg::MON_DEC))
        begin
            check_code = cdo_pkg::ST_BAD_MONTH;
        end
        else if ((day_reg == 5'd0) || (day_reg > dim_cur))
        begin
            check_code = cdo_pkg::ST_BAD_DAY;
        end
        else
        begin
            check_code = cdo_pkg::ST_OK;
        end
    end

    assign doy     = cdo_pkg::cum_days(month_reg, leap_cur) + 9'(day_reg) - 9'd1;
    assign r_start = $signed({8'd0, doy}) + $signed({off_reg[cdo_pkg::OFF_W-1], off_reg});

    // weekday of 1 January repeats every 400 years, so work from y mod 400
    always_comb
    begin
        if (r400_reg == 9'd0)
        begin
            c100 = 3'd0;
        end
        else if (r400_reg <= 9'd100)
        begin
            c100 = 3'd1;
        end
        else if (r400_reg <= 9'd200)
        begin
            c100 = 3'd2;
        end
        else if (r400_reg <= 9'd300)
        begin
            c100 = 3'd3;
        end
        else
        begin
            c100 = 3'd4;
        end
    end

    assign t4     = (10'(r400_reg) + 10'd3) >> 2;
    assign x_jan1 = 10'(r400_reg) + t4 - 10'(c100) + 10'(r400_reg != 9'd0) + 10'd5;

    assign wd_mod    = cdo_pkg::mod7(sum_reg);
    assign step_up   = leap_cur ? 2'd2 : 2'd1;
    assign step_down = leap_prev ? 2'd2 : 2'd1;
    assign wd_up     = (4'(wd_reg) + 4'(step_up) >= 4'd7) ? 4'(wd_reg) + 4'(step_up) - 4'd7
                                                           : 4'(wd_reg) + 4'(step_up);
    assign wd_down   = (4'(wd_reg) >= 4'(step_down)) ? 4'(wd_reg) - 4'(step_down)
                                                      : 4'(wd_reg) + 4'd7 - 4'(step_down);

    assign stat.bad      = (check_code != cdo_pkg::ST_OK);
    assign stat.r_neg    = r_reg[cdo_pkg::R_W-1];
    assign stat.r_ge_len = !r_reg[cdo_pkg::R_W-1] && (r_reg[15:0] >= 16'(len_cur));
    assign stat.at_min   = (year_reg == year_min);
    assign stat.at_max   = (year_reg == year_max);
    assign stat.m_more   = (month_reg < cdo_pkg::MON_DEC) && (r_reg[15:0] >= 16'(dim_cur));

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            cdo_pkg::OP_LOAD:
            begin
                day_reg   <= start_day;
                month_reg <= start_month;
                year_reg  <= start_year;
                off_reg   <= day_offset;
            end
            cdo_pkg::OP_DIV:
            begin
                q100_reg <= q_prod[26:19];
            end
            cdo_pkg::OP_MOD:
            begin
                r100_reg <= 7'(year_reg - 14'(q100_reg) * 14'd100);
                r400_reg <= 9'(year_reg - 14'(q100_reg[7:2]) * 14'd400);
            end
            cdo_pkg::OP_CHECK:
            begin
                status_reg <= check_code;
                r_reg      <= r_start;
                sum_reg    <= x_jan1[8:0];
                wd_reg     <= '0;
            end
            cdo_pkg::OP_JAN1:
            begin
                wd_reg <= wd_mod;
            end
            cdo_pkg::OP_DEC:
            begin
                year_reg <= year_reg - 14'd1;
                r100_reg <= r100_prev;
                r400_reg <= r400_prev;
                r_reg    <= r_reg + $signed(17'(len_prev));
                wd_reg   <= wd_down[cdo_pkg::WD_W-1:0];
            end
            cdo_pkg::OP_INC:
            begin
                year_reg <= year_reg + 14'd1;
                r100_reg <= r100_succ;
                r400_reg <= r400_succ;
                r_reg    <= r_reg - $signed(17'(len_cur));
                wd_reg   <= wd_up[cdo_pkg::WD_W-1:0];
            end
            cdo_pkg::OP_SAT_LO:
            begin
                r_reg      <= '0;
                status_reg <= cdo_pkg::ST_SAT;
            end
            cdo_pkg::OP_SAT_HI:
            begin
                r_reg      <= $signed(17'(len_cur - 9'd1));
                status_reg <= cdo_pkg::ST_SAT;
            end
            cdo_pkg::OP_YEAR_END:
            begin
                sum_reg   <= 9'(wd_reg) + r_reg[8:0];
                month_reg <= cdo_pkg::MON_JAN;
            end
            cdo_pkg::OP_MSTEP:
            begin
                r_reg     <= r_reg - $signed(17'(dim_cur));
                month_reg <= month_reg + 4'd1;
            end
            cdo_pkg::OP_MONTH_END:
            begin
                day_reg <= r_reg[cdo_pkg::DAY_W-1:0] + 5'd1;
            end
            cdo_pkg::OP_WDAY:
            begin
                wd_reg <= wd_mod;
            end
            cdo_pkg::OP_OUT:
            begin
                res_day_reg    <= day_reg;
                res_month_reg  <= month_reg;
                res_year_reg   <= year_reg;
                res_wd_reg     <= wd_reg;
                res_status_reg <= status_reg;
            end
            default:
            begin
                wd_reg <= wd_reg;
            end
        endcase
    end

    assign result_day   = res_day_reg;
    assign result_month = res_month_reg;
    assign result_year  = res_year_reg;
    assign weekday      = res_wd_reg;
    assign status       = res_status_reg;

`ifndef SYNTH
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == cdo_pkg::OP_INC || cmd.op == cdo_pkg::OP_DEC)
        |=> (year_reg >= year_min && year_reg <= year_max))
        else $error("year walk left the configured range");

    a_residue_track: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == cdo_pkg::OP_INC || cmd.op == cdo_pkg::OP_DEC)
        |=> (r100_reg < 7'd100 && r400_reg < 9'd400
             && r100_reg[1:0] == year_reg[1:0] && r400_reg[1:0] == year_reg[1:0]))
        else $error("year residues out of step with the year");

    a_sat_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == cdo_pkg::OP_SAT_LO || cmd.op == cdo_pkg::OP_SAT_HI)
        |=> (!stat.r_neg && !stat.r_ge_len && status_reg == cdo_pkg::ST_SAT))
        else $error("saturation did not land inside the year");

    a_month_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == cdo_pkg::OP_MONTH_END)
        |-> (month_reg >= cdo_pkg::MON_JAN && month_reg <= cdo_pkg::MON_DEC
             && r_reg[cdo_pkg::R_W-1:5] == 12'd0 && r_reg[4:0] != 5'd31))
        else $error("month walk ended outside a month");

    a_weekday: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == cdo_pkg::OP_JAN1 || cmd.op == cdo_pkg::OP_WDAY)
        |=> (wd_reg != 3'd7))
        else $error("weekday reduction out of range");
`endif

endmodule

// File: rtl/core/calendar_date_offset.sv
// calendar_date_offset: top level of the Gregorian date offset block.
// Depends on cdo_pkg, cdo_regs, cdo_ctrl and cdo_dpath.
//
// Adds a signed day offset to a Gregorian date and returns the new date, its
// weekday (Monday is 0) and a status. One item is worked at a time: after the
// input transfer the block runs the start-date checks in S_DIV, S_MOD and
// S_CHECK (a reciprocal multiply gives the year's residues mod 100 and 400),
// finds the weekday of 1 January, then walks the result one calendar year per
// cycle and then one month per cycle, reduces the weekday and loads the
// output register. The year walk, which crosses 0 to about 90 year
// boundaries for a 16-bit offset, is the dominant part of the work; a result
// that saturates passes through a clamp step in the year walk. A start date
// that fails a check goes from the checks straight to the output register,
// skipping the year and month walks and the weekday reduction. A new
// item is taken as soon as the previous one sits in the output register,
// even while that result still waits for m_tready. An invalid start date
// is echoed with weekday 0 and its status code; a result outside the
// configured year range saturates to 1 January of year_min or 31 December of
// year_max with status 4. Program year_min and year_max only while idle.
module calendar_date_offset
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // start_day[4:0], start_month[8:5],
                                   // start_year[22:9], day_offset[38:23], zero[39]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_day[4:0], result_month[8:5],
                                   // result_year[22:9], weekday[25:23], zero[31:26]
    output logic [2:0]  m_tuser,   // status[2:0]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [cdo_pkg::YEAR_W-1:0]        year_min;
    logic [cdo_pkg::YEAR_W-1:0]        year_max;
    cdo_pkg::dp_cmd_t                  cmd;
    cdo_pkg::dp_stat_t                 stat;

    logic [cdo_pkg::DAY_W-1:0]         start_day;
    logic [cdo_pkg::MON_W-1:0]         start_month;
    logic [cdo_pkg::YEAR_W-1:0]        start_year;
    logic signed [cdo_pkg::OFF_W-1:0]  day_offset;

    logic [cdo_pkg::DAY_W-1:0]         result_day;
    logic [cdo_pkg::MON_W-1:0]         result_month;
    logic [cdo_pkg::YEAR_W-1:0]        result_year;
    logic [cdo_pkg::WD_W-1:0]          weekday;
    logic [cdo_pkg::ST_W-1:0]          status;

    // unpack the input transfer
    assign start_day   = s_tdata[4:0];
    assign start_month = s_tdata[8:5];
    assign start_year  = s_tdata[22:9];
    assign day_offset  = $signed(s_tdata[38:23]);

    cdo_regs u_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .year_min (year_min),
        .year_max (year_max)
    );

    cdo_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cdo_dpath u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .year_min     (year_min),
        .year_max     (year_max),
        .start_day    (start_day),
        .start_month  (start_month),
        .start_year   (start_year),
        .day_offset   (day_offset),
        .result_day   (result_day),
        .result_month (result_month),
        .result_year  (result_year),
        .weekday      (weekday),
        .status       (status)
    );

    // pack the result transfer, zero-fill the top six bits
    assign m_tdata = {6'd0, weekday, result_year, result_month, result_day};
    assign m_tuser = status;

endmodule
